@@ hw/rtl/dsd_pkg.sv @@
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the door servo sequencer with button debounce.
// ----------------------------------------------------------------------------
package dsd_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned RegW   = 16;
	localparam int unsigned IndexW = 3;

	typedef enum logic [1:0] {
		POS_CLOSED  = 2'd0,
		POS_OPENING = 2'd1,
		POS_OPEN    = 2'd2,
		POS_CLOSING = 2'd3
	} pos_t;

	typedef enum logic [1:0] {
		ACT_IDLE  = 2'd0,
		ACT_OPEN  = 2'd1,
		ACT_CLOSE = 2'd2,
		ACT_STOP  = 2'd3
	} act_t;

	localparam logic [IndexW-1:0] REG_DEBOUNCE    = 3'd0;
	localparam logic [IndexW-1:0] REG_OPEN_TIME   = 3'd1;
	localparam logic [IndexW-1:0] REG_CLOSE_TIME  = 3'd2;
	localparam logic [IndexW-1:0] REG_PULSE_STOP  = 3'd3;
	localparam logic [IndexW-1:0] REG_PULSE_OPEN  = 3'd4;
	localparam logic [IndexW-1:0] REG_PULSE_CLOSE = 3'd5;

	localparam logic [RegW-1:0] DEBOUNCE_RST    = 16'd30;
	localparam logic [RegW-1:0] OPEN_TIME_RST   = 16'd500;
	localparam logic [RegW-1:0] CLOSE_TIME_RST  = 16'd550;
	localparam logic [RegW-1:0] PULSE_STOP_RST  = 16'd1500;
	localparam logic [RegW-1:0] PULSE_OPEN_RST  = 16'd1900;
	localparam logic [RegW-1:0] PULSE_CLOSE_RST = 16'd1420;

	typedef struct packed {
		logic [RegW-1:0] debounce_ms;
		logic [RegW-1:0] open_time_ms;
		logic [RegW-1:0] close_time_ms;
		logic [RegW-1:0] pulse_stop;
		logic [RegW-1:0] pulse_open;
		logic [RegW-1:0] pulse_close;
	} cfg_t;

	typedef struct packed {
		logic [TimeW-1:0] now_ms;
		logic             button_level;
		act_t             action;
	} item_t;

	typedef struct packed {
		pos_t            door_state;
		logic [RegW-1:0] servo_pulse;
		logic            in_motion;
		logic            manual_move;
	} result_t;

endpackage

@@ hw/rtl/dsd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dsd_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module dsd_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [dsd_pkg::IndexW-1:0]   cfg_index,
	input  logic [dsd_pkg::RegW-1:0]     cfg_wdata,
	output dsd_pkg::cfg_t                cfg
);

	dsd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= dsd_pkg::DEBOUNCE_RST;
			cfg_q.open_time_ms  <= dsd_pkg::OPEN_TIME_RST;
			cfg_q.close_time_ms <= dsd_pkg::CLOSE_TIME_RST;
			cfg_q.pulse_stop    <= dsd_pkg::PULSE_STOP_RST;
			cfg_q.pulse_open    <= dsd_pkg::PULSE_OPEN_RST;
			cfg_q.pulse_close   <= dsd_pkg::PULSE_CLOSE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dsd_pkg::REG_DEBOUNCE:    cfg_q.debounce_ms   <= cfg_wdata;
				dsd_pkg::REG_OPEN_TIME:   cfg_q.open_time_ms  <= cfg_wdata;
				dsd_pkg::REG_CLOSE_TIME:  cfg_q.close_time_ms <= cfg_wdata;
				dsd_pkg::REG_PULSE_STOP:  cfg_q.pulse_stop    <= cfg_wdata;
				dsd_pkg::REG_PULSE_OPEN:  cfg_q.pulse_open    <= cfg_wdata;
				dsd_pkg::REG_PULSE_CLOSE: cfg_q.pulse_close   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/dsd_core.sv @@
// ----------------------------------------------------------------------------
// dsd_core
// Debounce and door state update for one poll, with the state registers.
// ----------------------------------------------------------------------------
module dsd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  dsd_pkg::item_t   item,
	input  dsd_pkg::cfg_t    cfg,
	output dsd_pkg::result_t result
);

	dsd_pkg::pos_t                 pos_q, pos_d;
	logic                          moving_q, moving_d;
	logic [dsd_pkg::TimeW-1:0]     start_q, start_d;
	logic                          last_raw_q;
	logic                          stable_q, stable_d;
	logic [dsd_pkg::TimeW-1:0]     change_q, change_d;
	logic                          manual_q, manual_d;
	logic [dsd_pkg::RegW-1:0]      servo_q, servo_d;

	logic [dsd_pkg::TimeW-1:0]     since_change;
	logic [dsd_pkg::TimeW-1:0]     since_start;
	logic [dsd_pkg::RegW-1:0]      duration;
	logic                          take_level;
	logic                          press;
	dsd_pkg::act_t                 act;

	always_comb begin
		change_d     = (item.button_level != last_raw_q) ? item.now_ms : change_q;
		since_change = item.now_ms - change_d;
		take_level   = (since_change >= {16'd0, cfg.debounce_ms}) &&
		               (item.button_level != stable_q);
		stable_d     = take_level ? item.button_level : stable_q;
		press        = take_level && !item.button_level && !moving_q &&
		               (pos_q == dsd_pkg::POS_CLOSED || pos_q == dsd_pkg::POS_OPEN);

		act = item.action;
		if (press) begin
			act = (pos_q == dsd_pkg::POS_CLOSED) ? dsd_pkg::ACT_OPEN : dsd_pkg::ACT_CLOSE;
		end

		duration    = (pos_q == dsd_pkg::POS_OPENING) ? cfg.open_time_ms : cfg.close_time_ms;
		since_start = item.now_ms - start_q;

		pos_d    = pos_q;
		moving_d = moving_q;
		start_d  = start_q;
		manual_d = manual_q;
		servo_d  = servo_q;

		if (moving_q) begin
			if (since_start >= {16'd0, duration}) begin
				servo_d  = cfg.pulse_stop;
				moving_d = 1'b0;
				if (pos_q == dsd_pkg::POS_OPENING) begin
					pos_d = dsd_pkg::POS_OPEN;
				end else if (pos_q == dsd_pkg::POS_CLOSING) begin
					pos_d = dsd_pkg::POS_CLOSED;
				end
			end
		end else begin
			case (act)
				dsd_pkg::ACT_OPEN: begin
					if (pos_q == dsd_pkg::POS_CLOSED) begin
						pos_d    = dsd_pkg::POS_OPENING;
						servo_d  = cfg.pulse_open;
						start_d  = item.now_ms;
						moving_d = 1'b1;
						manual_d = press;
					end
				end
				dsd_pkg::ACT_CLOSE: begin
					if (pos_q == dsd_pkg::POS_OPEN) begin
						pos_d    = dsd_pkg::POS_CLOSING;
						servo_d  = cfg.pulse_close;
						start_d  = item.now_ms;
						moving_d = 1'b1;
						manual_d = press;
					end
				end
				dsd_pkg::ACT_STOP: begin
					servo_d  = cfg.pulse_stop;
					moving_d = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= dsd_pkg::POS_CLOSED;
			moving_q   <= 1'b0;
			start_q    <= '0;
			last_raw_q <= 1'b1;
			stable_q   <= 1'b1;
			change_q   <= '0;
			manual_q   <= 1'b0;
			servo_q    <= dsd_pkg::PULSE_STOP_RST;
		end else if (step) begin
			pos_q      <= pos_d;
			moving_q   <= moving_d;
			start_q    <= start_d;
			last_raw_q <= item.button_level;
			stable_q   <= stable_d;
			change_q   <= change_d;
			manual_q   <= manual_d;
			servo_q    <= servo_d;
		end
	end

	assign result.door_state  = pos_d;
	assign result.servo_pulse = servo_d;
	assign result.in_motion   = moving_d;
	assign result.manual_move = manual_d;

endmodule

@@ hw/rtl/door_servo_sequencer_debounced_top.sv @@
// ----------------------------------------------------------------------------
// door_servo_sequencer_debounced_top
// Door servo sequencer with a time-debounced push button, stream interface.
// ----------------------------------------------------------------------------
// Each input beat is one poll and yields exactly one output beat. A poll is
// held in an input register, processed by the state update, and its result
// lands in an output register, so one poll per cycle is sustained while
// m_tready does not hold the output register. The single state update step,
// which reads the state left by the previous poll, sets this rate.
// Configuration writes take effect at once and belong between runs of polls.
module door_servo_sequencer_debounced_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // now_ms[31:0], button_level[32], action[34:33]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // door_state[1:0], servo_pulse[17:2], in_motion[18],
	                               // manual_move[19]
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	dsd_pkg::cfg_t    cfg;
	dsd_pkg::item_t   item_s1;
	logic             valid_s1;
	dsd_pkg::result_t result;
	dsd_pkg::result_t out_q;
	logic             out_valid_q;
	logic             advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.now_ms       <= s_tdata[31:0];
			item_s1.button_level <= s_tdata[32];
			item_s1.action       <= dsd_pkg::act_t'(s_tdata[34:33]);
		end
	end

	dsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.manual_move, out_q.in_motion, out_q.servo_pulse,
	                   out_q.door_state};

endmodule
